// File: hw/rtl/bts_pkg.sv
// Shared constants and types for the bilinear texture sampler.
package bts_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int STORE_DEPTH = 65536;
  localparam int FRAC        = 16;

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);   // size register width
  localparam int COORD_W = $clog2(MAX_SIDE);       // texel x or y
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int UV_W    = FRAC + 2;
  localparam int UVC_W   = FRAC + 1;               // clamped 0..ONE
  localparam int FX_W    = FRAC + COORD_W;
  localparam int ROW_W   = FRAC + 8;
  localparam int COL_W   = 2 * FRAC + 8;

  localparam logic [UVC_W-1:0] UV_ONE = UVC_W'(1) << FRAC;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] texel_index;
    logic [31:0]       texel_rgba;
    logic [UV_W-1:0]   u_coord;
    logic [UV_W-1:0]   v_coord;
  } entry_t;

endpackage

// File: hw/rtl/bts_front.sv
// Input queue: accepts items and holds them in order for the back end.
module bts_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  bts_pkg::entry_t in_entry,
  output logic            q_valid,
  output bts_pkg::entry_t q_entry,
  input  logic            q_pop
);

  bts_pkg::entry_t                 q_mem [bts_pkg::QDEPTH];
  logic [bts_pkg::QPTR_W-1:0]      wptr;
  logic [bts_pkg::QPTR_W-1:0]      rptr;
  logic [bts_pkg::QCNT_W-1:0]      count;
  logic                            push;
  logic                            pop;

  assign in_stall = (count == bts_pkg::QCNT_W'(bts_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: hw/rtl/bts_back.sv
// Execution pipeline: address math, replicated texel store, two-pass blend.
module bts_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bts_pkg::SIDE_W-1:0]   w_eff,
  input  logic [bts_pkg::SIDE_W-1:0]   h_eff,
  input  logic                         q_valid,
  input  bts_pkg::entry_t              q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic [7:0]                   alpha_out,
  output logic                         visible
);

  localparam int FRAC = bts_pkg::FRAC;
  localparam int CW   = bts_pkg::COORD_W;
  localparam int AW   = bts_pkg::ADDR_W;
  localparam int FXW  = bts_pkg::FX_W;
  localparam int RW   = bts_pkg::ROW_W;
  localparam int BW   = bts_pkg::COL_W;

  logic en;
  assign en    = !(out_valid && out_stall);
  assign q_pop = en;

  logic [CW-1:0] wm1, hm1;
  assign wm1 = CW'(w_eff - 1'b1);
  assign hm1 = CW'(h_eff - 1'b1);

  // stage 1: clamp and scale
  logic [bts_pkg::UVC_W-1:0] uc, vc;
  always_comb begin
    if (q_entry.u_coord[bts_pkg::UV_W-1]) uc = '0;
    else if (q_entry.u_coord[bts_pkg::UVC_W-1:0] > bts_pkg::UV_ONE) uc = bts_pkg::UV_ONE;
    else uc = q_entry.u_coord[bts_pkg::UVC_W-1:0];
    if (q_entry.v_coord[bts_pkg::UV_W-1]) vc = '0;
    else if (q_entry.v_coord[bts_pkg::UVC_W-1:0] > bts_pkg::UV_ONE) vc = bts_pkg::UV_ONE;
    else vc = q_entry.v_coord[bts_pkg::UVC_W-1:0];
  end

  logic           s1_v, s1_wr;
  logic [AW-1:0]  s1_idx;
  logic [31:0]    s1_rgba;
  logic [FXW-1:0] s1_fx, s1_fy;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wr   <= (q_entry.func == bts_pkg::FUNC_WRITE);
      s1_idx  <= q_entry.texel_index;
      s1_rgba <= q_entry.texel_rgba;
      s1_fx   <= FXW'(uc) * FXW'(wm1);
      s1_fy   <= FXW'(vc) * FXW'(hm1);
    end
  end

  // stage 2: integer parts, weights, neighbor clamp
  logic [CW-1:0] x0c, y0c;
  logic [CW-1:0] x1c, y1c;
  assign x0c = s1_fx[FXW-1:FRAC];
  assign y0c = s1_fy[FXW-1:FRAC];
  assign x1c = ({1'b0, x0c} + 1'b1 < w_eff) ? x0c + 1'b1 : wm1;
  assign y1c = ({1'b0, y0c} + 1'b1 < h_eff) ? y0c + 1'b1 : hm1;

  logic            s2_v, s2_wr;
  logic [AW-1:0]   s2_idx;
  logic [31:0]     s2_rgba;
  logic [CW-1:0]   s2_x0, s2_x1, s2_y0, s2_y1;
  logic [FRAC-1:0] s2_tx, s2_ty;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_wr   <= s1_wr;
      s2_idx  <= s1_idx;
      s2_rgba <= s1_rgba;
      s2_x0   <= x0c;
      s2_x1   <= x1c;
      s2_y0   <= y0c;
      s2_y1   <= y1c;
      s2_tx   <= s1_fx[FRAC-1:0];
      s2_ty   <= s1_fy[FRAC-1:0];
    end
  end

  // stage 3: row-major addresses of the four neighbors
  logic [AW-1:0] row0, row1;
  assign row0 = AW'(s2_y0) * AW'(w_eff);
  assign row1 = AW'(s2_y1) * AW'(w_eff);

  logic            s3_v, s3_wr;
  logic [AW-1:0]   s3_idx;
  logic [31:0]     s3_rgba;
  logic [AW-1:0]   s3_addr [4];
  logic [FRAC-1:0] s3_tx, s3_ty;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_wr      <= s2_wr;
      s3_idx     <= s2_idx;
      s3_rgba    <= s2_rgba;
      s3_addr[0] <= row0 + AW'(s2_x0);
      s3_addr[1] <= row0 + AW'(s2_x1);
      s3_addr[2] <= row1 + AW'(s2_x0);
      s3_addr[3] <= row1 + AW'(s2_x1);
      s3_tx      <= s2_tx;
      s3_ty      <= s2_ty;
    end
  end

  // stage 4: one store copy per neighbor; writes go to all copies in order
  logic            s4_v;
  logic [31:0]     s4_t [4];
  logic [FRAC-1:0] s4_tx, s4_ty;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [31:0] mem [bts_pkg::STORE_DEPTH];
    always_ff @(posedge clk) begin
      if (en && s3_v) begin
        if (s3_wr) mem[s3_idx] <= s3_rgba;
        s4_t[k] <= mem[s3_addr[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tx <= s3_tx;
      s4_ty <= s3_ty;
    end
  end

  // stage 5: blend along x on both rows
  logic [bts_pkg::UVC_W-1:0] itx;
  assign itx = bts_pkg::UV_ONE - {1'b0, s4_tx};

  logic                       s5_v;
  logic [bts_pkg::ROW_W-1:0]  s5_a [4];
  logic [bts_pkg::ROW_W-1:0]  s5_b [4];
  logic [FRAC-1:0]            s5_ty;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        s5_a[c] <= RW'(s4_t[0][8*c +: 8]) * RW'(itx) + RW'(s4_t[1][8*c +: 8]) * RW'(s4_tx);
        s5_b[c] <= RW'(s4_t[2][8*c +: 8]) * RW'(itx) + RW'(s4_t[3][8*c +: 8]) * RW'(s4_tx);
      end
      s5_ty <= s4_ty;
    end
  end

  // stage 6: blend along y
  logic [bts_pkg::UVC_W-1:0] ity;
  assign ity = bts_pkg::UV_ONE - {1'b0, s5_ty};

  logic                      s6_v;
  logic [bts_pkg::COL_W-1:0] s6_bl [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        s6_bl[c] <= BW'(s5_a[c]) * BW'(ity) + BW'(s5_b[c]) * BW'(s5_ty);
      end
    end
  end

  // stage 7: round half up and register the result
  logic [7:0] rnd [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [bts_pkg::COL_W:0] sum;
      sum = {1'b0, s6_bl[c]} + ((bts_pkg::COL_W+1)'(1) << (2*FRAC - 1));
      rnd[c] = (sum[bts_pkg::COL_W:2*FRAC] > 9'd255) ? 8'hFF : sum[2*FRAC +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red       <= rnd[0];
      green     <= rnd[1];
      blue      <= rnd[2];
      alpha_out <= rnd[3];
      visible   <= (s6_bl[3] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      s6_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= q_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v && !s3_wr;   // write items end at the store
      s5_v      <= s4_v;
      s6_v      <= s5_v;
      out_valid <= s6_v;
    end
  end

endmodule

// File: hw/rtl/bilinear_texture_sampler.sv
// Top level of the bilinear RGBA8 texture sampler.
//
//   channel | direction | handshake          | payload
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//   in      | in        | in_valid, in_stall | func, texel_index, texel_rgba, u_coord, v_coord
//   out     | out       | out_valid,out_stall| red, green, blue, alpha_out, visible
//
// One item per cycle sustained while out_stall is low; a sample taken from
// the 4-entry input queue passes s1 to s6 and the output register. Four
// copies of the texel store give the four neighbor reads at once; writes
// update all copies. Reset clears the queue, the pipeline valids and sets
// both sizes to 1; the texel store is not cleared. out_stall with out_valid
// high freezes the whole back end, the queue keeps taking items until full.
module bilinear_texture_sampler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bts_pkg::SIDE_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [15:0]                 texel_index,
  input  logic [31:0]                 texel_rgba,
  input  logic signed [17:0]          u_coord,
  input  logic signed [17:0]          v_coord,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [7:0]                  alpha_out,
  output logic                        visible
);

  logic [bts_pkg::SIDE_W-1:0] tex_width, tex_height;
  logic [bts_pkg::SIDE_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= bts_pkg::SIDE_W'(1);
      tex_height <= bts_pkg::SIDE_W'(1);
    end else if (cfg_we) begin
      case (bts_pkg::reg_idx_t'(cfg_index))
        bts_pkg::REG_WIDTH:  tex_width  <= cfg_data;
        bts_pkg::REG_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize as the maximum side
  always_comb begin
    if (tex_width == '0) w_eff = bts_pkg::SIDE_W'(1);
    else if (tex_width > bts_pkg::SIDE_W'(bts_pkg::MAX_SIDE))
      w_eff = bts_pkg::SIDE_W'(bts_pkg::MAX_SIDE);
    else w_eff = tex_width;
    if (tex_height == '0) h_eff = bts_pkg::SIDE_W'(1);
    else if (tex_height > bts_pkg::SIDE_W'(bts_pkg::MAX_SIDE))
      h_eff = bts_pkg::SIDE_W'(bts_pkg::MAX_SIDE);
    else h_eff = tex_height;
  end

  bts_pkg::entry_t in_entry, q_entry;
  logic            q_valid, q_pop;

  always_comb begin
    in_entry.func        = bts_pkg::func_t'(func);
    in_entry.texel_index = texel_index;
    in_entry.texel_rgba  = texel_rgba;
    in_entry.u_coord     = u_coord;
    in_entry.v_coord     = v_coord;
  end

  bts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_entry (in_entry),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  bts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha_out (alpha_out),
    .visible   (visible)
  );

endmodule

// File: dv/bilinear_texture_sampler_tb.sv
// Self-checking testbench for the bilinear RGBA8 texture sampler.
module bilinear_texture_sampler_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 30;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       vis;
  } pixel_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [bts_pkg::SIDE_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic func = 0;
  logic [15:0] texel_index = '0;
  logic [31:0] texel_rgba = '0;
  logic signed [17:0] u_coord = '0;
  logic signed [17:0] v_coord = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] red, green, blue, alpha_out;
  logic visible;

  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  bit hold_req = 0;
  int hold_left = 0;
  bit in_took = 0;

  bilinear_texture_sampler dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  class texture_scoreboard;
    logic [31:0] texels [0:bts_pkg::STORE_DEPTH-1];
    logic [8:0] width_raw = 1;
    logic [8:0] height_raw = 1;
    pixel_t pending_pixels[$];

    function longint unsigned side(logic [8:0] raw);
      if (raw == 0) return 1;
      if (raw > bts_pkg::MAX_SIDE) return bts_pkg::MAX_SIDE;
      return raw;
    endfunction

    function longint unsigned clamp_uv(logic [17:0] c);
      if (c[17]) return 0;
      if (c > 18'd65536) return 65536;
      return c;
    endfunction

    function void note_input(logic f, logic [15:0] idx, logic [31:0] rgba,
                             logic [17:0] uc, logic [17:0] vc);
      longint unsigned w, h, fx, fy, x0, y0, x1, y1, tx, ty, pa, pb, blend;
      logic [31:0] t [4];
      logic [7:0] ch [4];
      pixel_t px;
      if (f == bts_pkg::FUNC_WRITE) begin
        texels[idx] = rgba;
        return;
      end
      w = side(width_raw);
      h = side(height_raw);
      fx = clamp_uv(uc) * (w - 1);
      fy = clamp_uv(vc) * (h - 1);
      x0 = fx >> 16;
      y0 = fy >> 16;
      tx = fx & 16'hFFFF;
      ty = fy & 16'hFFFF;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      t[0] = texels[y0 * w + x0];
      t[1] = texels[y0 * w + x1];
      t[2] = texels[y1 * w + x0];
      t[3] = texels[y1 * w + x1];
      for (int c = 0; c < 4; c++) begin
        pa = t[0][8*c +: 8] * (65536 - tx) + t[1][8*c +: 8] * tx;
        pb = t[2][8*c +: 8] * (65536 - tx) + t[3][8*c +: 8] * tx;
        blend = pa * (65536 - ty) + pb * ty;
        ch[c] = 8'((blend + (64'd1 << 31)) >> 32);
        if (c == 3) px.vis = (blend > 0);
      end
      px.r = ch[0];
      px.g = ch[1];
      px.b = ch[2];
      px.a = ch[3];
      pending_pixels = {pending_pixels, px};
    endfunction

    task check_result(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, red", got.r, 0);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.r !== want.r) report_mismatch("red", got.r, want.r);
      if (got.g !== want.g) report_mismatch("green", got.g, want.g);
      if (got.b !== want.b) report_mismatch("blue", got.b, want.b);
      if (got.a !== want.a) report_mismatch("alpha_out", got.a, want.a);
      if (got.vis !== want.vis) report_mismatch("visible", got.vis, want.vis);
    endtask
  endclass

  texture_scoreboard sb = new();

  // accept both channels at the rising edge; watchdog on silence
  always @(posedge clk) begin
    in_took = !rst && in_valid && !in_stall;
    if (in_took) sb.note_input(func, texel_index, texel_rgba, u_coord, v_coord);
    if (!rst && out_valid && !out_stall)
      sb.check_result('{red, green, blue, alpha_out, visible});
    if (rst || in_took || cfg_we || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      case (stall_mode)
        2: out_stall <= ($urandom_range(0, 99) < 78);
        3: out_stall <= ($urandom_range(0, 99) < 7);
        default: out_stall <= 0;
      endcase
    end
  end

  task automatic send_item(logic f, logic [15:0] idx, logic [31:0] rgba,
                           logic [17:0] uc, logic [17:0] vc);
    int gap;
    gap = 0;
    if (stall_mode == 1) while ($urandom_range(0, 99) < 78) gap++;
    if (stall_mode == 3) while ($urandom_range(0, 99) < 7) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    func <= f;
    texel_index <= idx;
    texel_rgba <= rgba;
    u_coord <= uc;
    v_coord <= vc;
    do @(negedge clk); while (!in_took);
  endtask

  function automatic logic [31:0] pick_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 7))
      0: t = 32'hFFFF_FFFF;
      1: t[31:24] = 8'h00;
      2: t = 32'h0;
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic [17:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 18'($urandom);
      1: return 18'd0;
      2: return 18'd65536;
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic write_texel(int idx);
    send_item(bts_pkg::FUNC_WRITE, 16'(idx), pick_texel(), 18'($urandom), 18'($urandom));
  endtask

  task automatic sample(logic [17:0] uc, logic [17:0] vc);
    send_item(bts_pkg::FUNC_SAMPLE, 16'($urandom), $urandom, uc, vc);
  endtask

  // block must be idle here
  task automatic set_size(logic [8:0] w, logic [8:0] h);
    cfg_we <= 1;
    cfg_index <= bts_pkg::REG_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= bts_pkg::REG_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 0;
    sb.width_raw = w;
    sb.height_raw = h;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int sizes [12][2] = '{'{4, 4}, '{256, 1}, '{0, 0}, '{1, 511}, '{7, 3},
                          '{8, 8}, '{13, 9}, '{2, 2}, '{5, 11}, '{3, 1},
                          '{0, 3}, '{6, 1}};
    logic [17:0] corners [6] = '{18'h20000, 18'h1FFFF, 18'd0, 18'd65536,
                                 18'd65535, 18'd32768};
    int area;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    for (int p = 0; p < 12; p++) begin
      stall_mode = p % 4;
      set_size(9'(sizes[p][0]), 9'(sizes[p][1]));
      area = int'(sb.side(9'(sizes[p][0])) * sb.side(9'(sizes[p][1])));
      for (int i = 0; i < area; i++) write_texel(i);
      if (p == 0)
        foreach (corners[i]) foreach (corners[j]) sample(corners[i], corners[j]);
      if (p == 7) hold_req = 1;
      for (int n = 0; n < 51; n++) begin
        case ($urandom_range(0, 9))
          0: write_texel($urandom_range(0, area - 1));
          1: send_item(bts_pkg::FUNC_WRITE, 16'($urandom_range(area, 65535)), pick_texel(),
                       18'($urandom), 18'($urandom));
          default: sample(pick_coord(), pick_coord());
        endcase
      end
      drain();
    end
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
